// File: rtl/core/oagc_pkg.sv
// ----------------------------------------------------------------------------
// OTP white balance gain calibration package
// Widths, reset values, register indexes and the restoring-division step
// shared by the calibration pipeline.
// ----------------------------------------------------------------------------
package oagc_pkg;

    // Field widths.
    localparam int RATIO_W  = 8;
    localparam int GAIN_W   = 16;
    localparam int UNITY_SH = 7;                   // 128 = 1 << 7
    localparam int RAW_W    = RATIO_W + UNITY_SH;  // 128 * golden fits in 15 bits
    localparam int NUM2_W   = RAW_W + UNITY_SH;    // 128 * raw gain fits in 22 bits
    localparam int DEN_W    = RATIO_W;             // both divisors are at most 8 bits

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 2 * RATIO_W;
    localparam int M_TDATA_W = 3 * GAIN_W;
    localparam int CFG_IDX_W = 1;

    // Constants.
    localparam logic [RATIO_W-1:0] GOLDEN_RG_RESET = 8'h90;
    localparam logic [RATIO_W-1:0] GOLDEN_BG_RESET = 8'h95;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 16'd128;
    localparam logic [NUM2_W-1:0]  GREEN_NUM       = 22'd16384; // 128 * 128
    localparam logic [RAW_W-1:0]   GREEN_RAW       = 15'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_RG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_BG = 1'b1;

    // Item state while the raw red and blue gains are divided out.
    typedef struct packed {
        logic [RAW_W-1:0] q_r;
        logic [RAW_W-1:0] q_b;
        logic [DEN_W-1:0] rem_r;
        logic [DEN_W-1:0] rem_b;
        logic [DEN_W-1:0] den_r;
        logic [DEN_W-1:0] den_b;
        logic             zero;
        logic             wb;
    } t_div1;

    // Item state while the gains are normalised against the base.
    typedef struct packed {
        logic [NUM2_W-1:0] q_r;
        logic [NUM2_W-1:0] q_g;
        logic [NUM2_W-1:0] q_b;
        logic [DEN_W-1:0]  rem_r;
        logic [DEN_W-1:0]  rem_g;
        logic [DEN_W-1:0]  rem_b;
        logic [DEN_W-1:0]  base;
        logic              zero;
        logic              wb;
    } t_div2;

    // One restoring-division step: returns the new remainder and the quotient bit.
    function automatic logic [DEN_W:0] f_div_step(
        input logic [DEN_W-1:0] rem,
        input logic             din,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        trial = {rem, din};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            f_div_step = {diff[DEN_W-1:0], 1'b1};
        end else begin
            f_div_step = {trial[DEN_W-1:0], 1'b0};
        end
    endfunction

    // One quotient bit of both raw gain divisions.
    function automatic t_div1 f_div1_step(input t_div1 s);
        t_div1          res;
        logic [DEN_W:0] st_r;
        logic [DEN_W:0] st_b;
        res       = s;
        st_r      = f_div_step(s.rem_r, s.q_r[RAW_W-1], s.den_r);
        st_b      = f_div_step(s.rem_b, s.q_b[RAW_W-1], s.den_b);
        res.rem_r = st_r[DEN_W:1];
        res.rem_b = st_b[DEN_W:1];
        res.q_r   = {s.q_r[RAW_W-2:0], st_r[0]};
        res.q_b   = {s.q_b[RAW_W-2:0], st_b[0]};
        f_div1_step = res;
    endfunction

    // One quotient bit of the three normalising divisions.
    function automatic t_div2 f_div2_step(input t_div2 s);
        t_div2          res;
        logic [DEN_W:0] st_r;
        logic [DEN_W:0] st_g;
        logic [DEN_W:0] st_b;
        res       = s;
        st_r      = f_div_step(s.rem_r, s.q_r[NUM2_W-1], s.base);
        st_g      = f_div_step(s.rem_g, s.q_g[NUM2_W-1], s.base);
        st_b      = f_div_step(s.rem_b, s.q_b[NUM2_W-1], s.base);
        res.rem_r = st_r[DEN_W:1];
        res.rem_g = st_g[DEN_W:1];
        res.rem_b = st_b[DEN_W:1];
        res.q_r   = {s.q_r[NUM2_W-2:0], st_r[0]};
        res.q_g   = {s.q_g[NUM2_W-2:0], st_g[0]};
        res.q_b   = {s.q_b[NUM2_W-2:0], st_b[0]};
        f_div2_step = res;
    endfunction

endpackage

// File: rtl/core/otp_awb_gain_calibration_core.sv
// ----------------------------------------------------------------------------
// OTP white balance gain calibration core
// Turns measured R/G and B/G ratio bytes into normalised R, G and B gains.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tdata carries measured_rg (bits 7:0) and measured_bg
//   (bits 15:8); tuser carries wb_valid. Output stream: tdata carries
//   red_gain, green_gain and blue_gain, 16 bits each from the lowest bits
//   up; tuser carries apply_gains. One result leaves for every request taken.
//   The configuration channel writes the golden R/G ratio (index 0) and the
//   golden B/G ratio (index 1); it is always ready. The user writes it only
//   while the core is idle; the core itself does not enforce this.
//   The pipeline has 16 stages for the 15-bit raw gain division (an entry
//   stage, then one bit per stage), 23 stages of base selection and the
//   22-bit normalising division, and one output register. It takes one
//   request per cycle while the output is not stalled.
//   When the receiver stalls, valid items close up behind the output
//   register; the input stays ready until every stage holds an item.
//   Synchronous reset empties the pipeline and restores the golden ratios to
//   144 and 149.
// ----------------------------------------------------------------------------
module otp_awb_gain_calibration_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [oagc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [oagc_pkg::RATIO_W-1:0]      i_cfg_data,
    // Request stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [oagc_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // measured_rg, measured_bg
    input  logic                              i_s_axis_tuser,  // wb_valid
    // Result stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [oagc_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,  // red, green, blue gain
    output logic                              o_m_axis_tuser   // apply_gains
);
    import oagc_pkg::*;

    localparam int D2_FIRST = RAW_W + 1;
    localparam int OUT_IDX  = D2_FIRST + NUM2_W + 1;
    localparam int NSTAGES  = OUT_IDX + 1;

    logic [RATIO_W-1:0] r_golden_rg;
    logic [RATIO_W-1:0] r_golden_bg;

    logic [NSTAGES-1:0] r_vld;
    logic [NSTAGES:0]   w_rdy;
    logic [NSTAGES-1:0] w_vin;

    t_div1 r_d1 [0:RAW_W];
    t_div1 n_d1 [0:RAW_W];
    t_div2 r_d2 [0:NUM2_W];
    t_div2 n_d2 [0:NUM2_W];

    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;
    logic                 r_out_apply;
    logic                 n_out_apply;

    logic [RATIO_W-1:0] w_mrg;
    logic [RATIO_W-1:0] w_mbg;
    logic [RAW_W-1:0]   w_min_rb;
    logic [RAW_W-1:0]   w_base;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_golden_rg <= GOLDEN_RG_RESET;
            r_golden_bg <= GOLDEN_BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GOLDEN_RG: r_golden_rg <= i_cfg_data;
                CFG_GOLDEN_BG: r_golden_bg <= i_cfg_data;
            endcase
        end
    end

    // Each stage takes a new item when it is empty or its item moves on.
    assign w_rdy[NSTAGES] = i_m_axis_tready;
    assign w_vin[0]       = i_s_axis_tvalid;

    genvar k;
    generate
        for (k = 0; k < NSTAGES; k++) begin : g_ctrl
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
            if (k > 0) begin : g_vin
                assign w_vin[k] = r_vld[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    endgenerate

    assign o_s_axis_tready = w_rdy[0];

    // Entry stage: numerators 128 * golden, divisors the measured ratios.
    assign w_mrg = i_s_axis_tdata[RATIO_W-1:0];
    assign w_mbg = i_s_axis_tdata[S_TDATA_W-1:RATIO_W];

    always_comb begin
        n_d1[0].q_r   = {r_golden_rg, {UNITY_SH{1'b0}}};
        n_d1[0].q_b   = {r_golden_bg, {UNITY_SH{1'b0}}};
        n_d1[0].rem_r = '0;
        n_d1[0].rem_b = '0;
        n_d1[0].den_r = w_mrg;
        n_d1[0].den_b = w_mbg;
        n_d1[0].zero  = (w_mrg == '0) || (w_mbg == '0);
        n_d1[0].wb    = i_s_axis_tuser;
    end

    // Raw gain division, one quotient bit per stage.
    generate
        for (k = 0; k <= RAW_W; k++) begin : g_d1
            if (k > 0) begin : g_step
                assign n_d1[k] = f_div1_step(r_d1[k-1]);
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_d1[k] <= n_d1[k];
                end
            end
        end
    endgenerate

    // Base selection: the smallest of the raw red, blue and fixed green gains.
    assign w_min_rb = (r_d1[RAW_W].q_r < r_d1[RAW_W].q_b) ? r_d1[RAW_W].q_r
                                                          : r_d1[RAW_W].q_b;
    assign w_base   = (w_min_rb < GREEN_RAW) ? w_min_rb : GREEN_RAW;

    always_comb begin
        n_d2[0].q_r   = {r_d1[RAW_W].q_r, {UNITY_SH{1'b0}}};
        n_d2[0].q_g   = GREEN_NUM;
        n_d2[0].q_b   = {r_d1[RAW_W].q_b, {UNITY_SH{1'b0}}};
        n_d2[0].rem_r = '0;
        n_d2[0].rem_g = '0;
        n_d2[0].rem_b = '0;
        n_d2[0].base  = w_base[DEN_W-1:0];
        n_d2[0].zero  = r_d1[RAW_W].zero || (w_base == '0);
        n_d2[0].wb    = r_d1[RAW_W].wb;
    end

    // Normalising division against the base, one quotient bit per stage.
    generate
        for (k = 0; k <= NUM2_W; k++) begin : g_d2
            if (k > 0) begin : g_step
                assign n_d2[k] = f_div2_step(r_d2[k-1]);
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy[D2_FIRST + k]) begin
                    r_d2[k] <= n_d2[k];
                end
            end
        end
    endgenerate

    // Output register: unity gains when a ratio or the base is zero.
    always_comb begin
        if (r_d2[NUM2_W].zero) begin
            n_out_data  = {UNITY_GAIN, UNITY_GAIN, UNITY_GAIN};
            n_out_apply = 1'b0;
        end else begin
            n_out_data  = {r_d2[NUM2_W].q_b[GAIN_W-1:0],
                           r_d2[NUM2_W].q_g[GAIN_W-1:0],
                           r_d2[NUM2_W].q_r[GAIN_W-1:0]};
            n_out_apply = r_d2[NUM2_W].wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[OUT_IDX]) begin
            r_out_data  <= n_out_data;
            r_out_apply <= n_out_apply;
        end
    end

    assign o_m_axis_tvalid = r_vld[OUT_IDX];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_apply;

    // The input only stalls once every stage holds an item.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld))
        else $error("input stalled while the pipeline had a free stage");

    // The gain that served as base always normalises to unity.
    a_base_is_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[GAIN_W-1:0] == UNITY_GAIN)
                         || (o_m_axis_tdata[2*GAIN_W-1:GAIN_W] == UNITY_GAIN)
                         || (o_m_axis_tdata[3*GAIN_W-1:2*GAIN_W] == UNITY_GAIN))
        else $error("no normalised gain equals unity");

    // Green is 16384 over a base of at most 128, so it stays within these bounds.
    a_green_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2*GAIN_W-1:GAIN_W] >= UNITY_GAIN)
                         && (o_m_axis_tdata[2*GAIN_W-1:GAIN_W] <= GREEN_NUM[GAIN_W-1:0]))
        else $error("green gain out of range");

endmodule

// File: tb/sv/otp_awb_gain_calibration_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OTP white balance gain calibration core testbench
// Streams measured ratio requests through the core under several golden ratio
// settings and checks every result against a gain predictor kept in step with
// the configuration. Both stream sides idle in short random bursts.
// ----------------------------------------------------------------------------
module otp_awb_gain_calibration_core_tb;

    import oagc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int MAX_PRINTED = 100;

    // One calibration request: measured ratios and the group valid flag.
    typedef struct packed {
        logic [RATIO_W-1:0] rg;
        logic [RATIO_W-1:0] bg;
        logic               wb;
    } ratio_req_t;

    // One set of normalised gains.
    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
        logic              apply;
    } gain_set_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_GOLDEN_RG;
    logic [RATIO_W-1:0]     i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;   // measured_rg, measured_bg
    logic                   i_s_axis_tuser = 1'b0; // wb_valid
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;        // red_gain, green_gain, blue_gain
    logic                   o_m_axis_tuser;        // apply_gains

    // Golden ratios as the core should hold them.
    logic [RATIO_W-1:0]     golden_rg = GOLDEN_RG_RESET;
    logic [RATIO_W-1:0]     golden_bg = GOLDEN_BG_RESET;

    ratio_req_t             pending_ratios[$];
    gain_set_t              expected_gains[$];
    ratio_req_t             next_req;
    gain_set_t              want;
    int unsigned            cycles = 0;
    int unsigned            mismatches = 0;
    int unsigned            src_gap = 0;
    int unsigned            snk_gap = 0;
    bit                     quiet = 1'b0;

    otp_awb_gain_calibration_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gain predictor: raw gains against the golden ratios, then normalised
    // against the smallest of the three.
    function automatic gain_set_t calc_gains(input logic [RATIO_W-1:0] mrg,
                                             input logic [RATIO_W-1:0] mbg,
                                             input logic wb,
                                             input logic [RATIO_W-1:0] grg,
                                             input logic [RATIO_W-1:0] gbg);
        logic [31:0] r_raw;
        logic [31:0] b_raw;
        logic [31:0] base;
        gain_set_t   res;
        res.red   = UNITY_GAIN;
        res.green = UNITY_GAIN;
        res.blue  = UNITY_GAIN;
        res.apply = 1'b0;
        if (mrg != 0 && mbg != 0) begin
            r_raw = (32'd128 * grg) / mrg;
            b_raw = (32'd128 * gbg) / mbg;
            base  = 32'd128;
            if (r_raw < base) base = r_raw;
            if (b_raw < base) base = b_raw;
            // A zero base leaves the unity gains in place.
            if (base != 0) begin
                res.red   = GAIN_W'((32'd128 * r_raw) / base);
                res.green = GAIN_W'((32'd128 * 32'd128) / base);
                res.blue  = GAIN_W'((32'd128 * b_raw) / base);
                res.apply = wb;
            end
        end
        return res;
    endfunction

    // Bursts of idling are allowed in two stretches out of three, and never
    // in the closing part of the run.
    function automatic bit bursts_allowed();
        return !quiet && ((cycles / 150) % 3 != 2);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    task automatic queue_ratio(input logic [RATIO_W-1:0] rg, input logic [RATIO_W-1:0] bg,
                               input logic wb);
        ratio_req_t req;
        req.rg = rg;
        req.bg = bg;
        req.wb = wb;
        pending_ratios.push_back(req);
    endtask

    // Random requests: mostly ratios close to the golden ratios, with zero
    // ratios, extremes and fully random bytes mixed in.
    task automatic queue_random(input int count);
        int         rv;
        int         bv;
        ratio_req_t req;
        for (int n = 0; n < count; n++) begin
            req.wb = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 19))
                0: begin
                    req.rg = '0;
                    req.bg = RATIO_W'($urandom_range(0, 255));
                end
                1: begin
                    req.rg = RATIO_W'($urandom_range(0, 255));
                    req.bg = '0;
                end
                2: begin
                    req.rg = $urandom_range(0, 1) ? 8'd255 : 8'd1;
                    req.bg = $urandom_range(0, 1) ? 8'd255 : 8'd1;
                end
                3, 4, 5, 6, 7, 8: begin
                    req.rg = RATIO_W'($urandom_range(0, 255));
                    req.bg = RATIO_W'($urandom_range(0, 255));
                end
                default: begin
                    rv = int'(golden_rg) + int'($urandom_range(0, 64)) - 32;
                    bv = int'(golden_bg) + int'($urandom_range(0, 64)) - 32;
                    if (rv < 1) rv = 1;
                    if (rv > 255) rv = 255;
                    if (bv < 1) bv = 1;
                    if (bv > 255) bv = 255;
                    req.rg = RATIO_W'(rv);
                    req.bg = RATIO_W'(bv);
                end
            endcase
            pending_ratios.push_back(req);
        end
    endtask

    // Waits until every queued request has been taken and its result seen.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ratios.size() != 0 || i_s_axis_tvalid || expected_gains.size() != 0);
    endtask

    // One register write; the predictor copy follows on the handshake.
    task automatic write_golden(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GOLDEN_RG)
            golden_rg = val;
        else
            golden_bg = val;
    endtask

    // Request driver: records the prediction of each accepted request and
    // presents the next one, with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_gains.push_back(calc_gains(i_s_axis_tdata[RATIO_W-1:0],
                                                    i_s_axis_tdata[2*RATIO_W-1:RATIO_W],
                                                    i_s_axis_tuser, golden_rg, golden_bg));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_ratios.size() != 0 && bursts_allowed() &&
                             $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_ratios.size() != 0) begin
                    next_req = pending_ratios.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {next_req.bg, next_req.rg};
                    i_s_axis_tuser  <= next_req.wb;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result with the oldest prediction and
    // stalls the output at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_gains.size() == 0) begin
                flag_mismatch("result with no request outstanding");
            end else begin
                want = expected_gains.pop_front();
                if (o_m_axis_tdata[GAIN_W-1:0] !== want.red)
                    flag_mismatch($sformatf("red_gain %0d, expected %0d",
                                            o_m_axis_tdata[GAIN_W-1:0], want.red));
                if (o_m_axis_tdata[2*GAIN_W-1:GAIN_W] !== want.green)
                    flag_mismatch($sformatf("green_gain %0d, expected %0d",
                                            o_m_axis_tdata[2*GAIN_W-1:GAIN_W], want.green));
                if (o_m_axis_tdata[3*GAIN_W-1:2*GAIN_W] !== want.blue)
                    flag_mismatch($sformatf("blue_gain %0d, expected %0d",
                                            o_m_axis_tdata[3*GAIN_W-1:2*GAIN_W], want.blue));
                if (o_m_axis_tuser !== want.apply)
                    flag_mismatch($sformatf("apply_gains %0b, expected %0b",
                                            o_m_axis_tuser, want.apply));
            end
        end
        if (snk_gap != 0) begin
            snk_gap--;
            i_m_axis_tready <= 1'b0;
        end else if (bursts_allowed() && $urandom_range(0, 4) == 0) begin
            snk_gap = $urandom_range(0, 2);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset golden ratios: zero measured ratios, extremes, invalid group.
        queue_ratio(8'd0, 8'd0, 1'b1);
        queue_ratio(8'd0, 8'd77, 1'b1);
        queue_ratio(8'd77, 8'd0, 1'b1);
        queue_ratio(8'd144, 8'd149, 1'b1);
        queue_ratio(8'd255, 8'd255, 1'b1);
        queue_ratio(8'd1, 8'd1, 1'b1);
        queue_ratio(8'd255, 8'd255, 1'b0);
        queue_ratio(8'hAA, 8'h55, 1'b1);
        queue_ratio(8'h55, 8'hAA, 1'b0);
        wait_drained();

        // Widest spread of golden ratios: normalised gains overflow 16 bits.
        write_golden(CFG_GOLDEN_RG, 8'd255);
        write_golden(CFG_GOLDEN_BG, 8'd2);
        queue_ratio(8'd1, 8'd255, 1'b1);
        queue_ratio(8'd255, 8'd1, 1'b1);
        queue_ratio(8'd1, 8'd1, 1'b0);
        wait_drained();

        write_golden(CFG_GOLDEN_RG, 8'd2);
        write_golden(CFG_GOLDEN_BG, 8'd255);
        queue_ratio(8'd255, 8'd1, 1'b1);
        queue_ratio(8'd1, 8'd255, 1'b1);
        wait_drained();

        // Golden ratios below range can give a zero base.
        write_golden(CFG_GOLDEN_RG, 8'd0);
        queue_ratio(8'd10, 8'd10, 1'b1);
        queue_ratio(8'd1, 8'd1, 1'b1);
        wait_drained();
        write_golden(CFG_GOLDEN_RG, 8'd255);
        write_golden(CFG_GOLDEN_BG, 8'd1);
        queue_ratio(8'd1, 8'd200, 1'b1);
        queue_ratio(8'd1, 8'd1, 1'b0);

        // Random phases, each under its own golden ratios.
        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_golden(CFG_GOLDEN_RG, GOLDEN_RG_RESET);
                    write_golden(CFG_GOLDEN_BG, GOLDEN_BG_RESET);
                end
                1: begin
                    write_golden(CFG_GOLDEN_RG, 8'd255);
                    write_golden(CFG_GOLDEN_BG, 8'd255);
                end
                2: begin
                    write_golden(CFG_GOLDEN_RG, 8'd2);
                    write_golden(CFG_GOLDEN_BG, 8'd2);
                end
                default: begin
                    write_golden(CFG_GOLDEN_RG, RATIO_W'($urandom_range(2, 255)));
                    write_golden(CFG_GOLDEN_BG, RATIO_W'($urandom_range(2, 255)));
                end
            endcase
            if (ph == 6)
                quiet = 1'b1;
            queue_random(65);
            // Once, the sender holds off until the pipeline has emptied.
            if (ph == 3)
                wait_drained();
            queue_random(65);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/oagc_pkg.sv
rtl/core/otp_awb_gain_calibration_core.sv
tb/sv/otp_awb_gain_calibration_core_tb.sv
